[rtl/rmrd_pkg.sv]
`timescale 1ns / 1ps

package rmrd_pkg;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_MARKER_VALUE = 1'b0,
        CFG_FRAME_SIZE   = 1'b1
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned LEN_W       = 9;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              frame_start;
        logic              is_marker;
    } rmrd_entry_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } rmrd_queue_status_t;

endpackage

[rtl/rmrd_front.sv]
`timescale 1ns / 1ps

module rmrd_front
(
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [rmrd_pkg::BYTE_W-1:0]            s_tdata,
    input  logic                                   s_tuser,
    input  logic [rmrd_pkg::BYTE_W-1:0]            marker_value,
    input  rmrd_pkg::rmrd_queue_status_t           queue_status,
    output logic                                   push,
    output rmrd_pkg::rmrd_entry_t                  push_entry
);

    // Take an item whenever the queue has a free slot
    assign s_tready = !queue_status.full;
    assign push     = s_tvalid && !queue_status.full;

    // Classify the byte against the marker
    always_comb
    begin
        push_entry.code_byte   = s_tdata;
        push_entry.frame_start = s_tuser;
        push_entry.is_marker   = (s_tdata == marker_value);
    end

endmodule

[rtl/rmrd_queue.sv]
`timescale 1ns / 1ps

module rmrd_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  rmrd_pkg::rmrd_entry_t         push_entry,
    input  logic                          pop,
    output rmrd_pkg::rmrd_entry_t         pop_entry,
    output rmrd_pkg::rmrd_queue_status_t  status
);

    localparam int unsigned PTR_W = $clog2(rmrd_pkg::QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(rmrd_pkg::QUEUE_DEPTH + 1);

    rmrd_pkg::rmrd_entry_t slot_reg [rmrd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(rmrd_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/rmrd_back.sv]
`timescale 1ns / 1ps

module rmrd_back
#(
    parameter int unsigned SIZE_BITS = 24
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [rmrd_pkg::BYTE_W-1:0]        marker_value,
    input  logic [SIZE_BITS-1:0]               frame_size,
    input  rmrd_pkg::rmrd_queue_status_t       queue_status,
    input  rmrd_pkg::rmrd_entry_t              pop_entry,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rmrd_pkg::BYTE_W-1:0]        run_value,
    output logic [rmrd_pkg::LEN_W-1:0]         run_length,
    output logic [SIZE_BITS-1:0]               total_written,
    output logic                               frame_done
);

    localparam int unsigned LEN_W = rmrd_pkg::LEN_W;
    localparam int unsigned CMP_W = (SIZE_BITS > LEN_W) ? SIZE_BITS : LEN_W;

    logic                  awaiting_reg, awaiting_next;
    logic [SIZE_BITS-1:0]  written_reg, written_next;
    logic                  out_valid_reg, out_valid_next;
    logic [rmrd_pkg::BYTE_W-1:0] value_reg, value_next;
    logic [LEN_W-1:0]      length_reg, length_next;
    logic [SIZE_BITS-1:0]  total_reg, total_next;
    logic                  done_reg, done_next;

    logic                  can_load;
    logic                  start_awaiting;
    logic [SIZE_BITS-1:0]  start_written;
    logic                  frame_full;
    logic                  emit;
    logic [rmrd_pkg::BYTE_W-1:0] req_value;
    logic [LEN_W-1:0]      req_len;
    logic [CMP_W-1:0]      room;
    logic [LEN_W-1:0]      clamp_len;
    logic [SIZE_BITS-1:0]  new_written;

    assign can_load = !out_valid_reg || out_ready;
    assign pop      = !queue_status.empty && can_load;

    // Apply the frame start, then decide what the byte does
    always_comb
    begin
        start_awaiting = pop_entry.frame_start ? 1'b0 : awaiting_reg;
        start_written  = pop_entry.frame_start ? '0 : written_reg;
        frame_full     = (start_written >= frame_size);
        emit           = 1'b0;
        req_value      = pop_entry.code_byte;
        req_len        = LEN_W'(1);
        if (!frame_full)
        begin
            if (start_awaiting)
            begin
                emit      = 1'b1;
                req_value = marker_value;
                req_len   = LEN_W'(pop_entry.code_byte) + LEN_W'(1);
            end
            else if (!pop_entry.is_marker)
            begin
                emit = 1'b1;
            end
        end
    end

    // Clamp the run to the room left in the frame
    always_comb
    begin
        room        = CMP_W'(frame_size - start_written);
        clamp_len   = (room < CMP_W'(req_len)) ? room[LEN_W-1:0] : req_len;
        new_written = SIZE_BITS'(CMP_W'(start_written) + CMP_W'(clamp_len));
    end

    // Update decoder state and the output register
    always_comb
    begin
        awaiting_next  = awaiting_reg;
        written_next   = written_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        length_next    = length_reg;
        total_next     = total_reg;
        done_next      = done_reg;
        if (can_load)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            awaiting_next = start_awaiting;
            written_next  = start_written;
            if (!frame_full)
            begin
                if (start_awaiting)
                begin
                    awaiting_next = 1'b0;
                end
                else if (pop_entry.is_marker)
                begin
                    awaiting_next = 1'b1;
                end
            end
            if (emit)
            begin
                written_next   = new_written;
                out_valid_next = 1'b1;
                value_next     = req_value;
                length_next    = clamp_len;
                total_next     = new_written;
                done_next      = (new_written == frame_size);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            awaiting_reg  <= awaiting_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        length_reg <= length_next;
        total_reg  <= total_next;
        done_reg   <= done_next;
    end

    assign out_valid     = out_valid_reg;
    assign run_value     = value_reg;
    assign run_length    = length_reg;
    assign total_written = total_reg;
    assign frame_done    = done_reg;

endmodule

[rtl/rle_marker_run_decoder_core.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_axis    in         s_tvalid/s_tready    tdata: code_byte; tuser: frame_start
// m_axis    out        m_tvalid/m_tready    tdata: run_value, run_length, total_written;
//                                           tlast: frame_done
// cfg       in         cfg_wr_en            cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; a result is registered
// in two steps after its item is taken: the item is written into the two-entry queue,
// then the back stage decodes it from the queue head into its output register.
// The back stage does the subtract, clamp and add on the frame count combinationally.
// rst_n clears the queue, decoder state, output valid and config registers at once.
// Output stalls back up through the queue; the front keeps taking items while it has room.

module rle_marker_run_decoder_core
#(
    parameter int unsigned SIZE_BITS = 24
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // code_byte
    input  logic                                  s_tuser,   // frame_start
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // run_value [7:0], run_length [16:8], total_written above, zero fill
    output logic [((17 + SIZE_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                  m_tlast,   // frame_done
    input  logic                                  cfg_wr_en,
    input  logic [rmrd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [SIZE_BITS-1:0]                  cfg_data
);

    localparam int unsigned PACK_W = 17 + SIZE_BITS;
    localparam int unsigned OUT_W  = ((PACK_W + 7) / 8) * 8;

    logic [rmrd_pkg::BYTE_W-1:0] marker_reg;
    logic [SIZE_BITS-1:0]        frame_size_reg;

    logic                          push;
    logic                          pop;
    rmrd_pkg::rmrd_entry_t         push_entry;
    rmrd_pkg::rmrd_entry_t         pop_entry;
    rmrd_pkg::rmrd_queue_status_t  queue_status;

    logic [rmrd_pkg::BYTE_W-1:0] run_value;
    logic [rmrd_pkg::LEN_W-1:0]  run_length;
    logic [SIZE_BITS-1:0]        total_written;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg     <= '0;
            frame_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rmrd_pkg::CFG_MARKER_VALUE: marker_reg     <= cfg_data[7:0];
                rmrd_pkg::CFG_FRAME_SIZE:   frame_size_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    rmrd_front u_front
    (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .marker_value (marker_reg),
        .queue_status (queue_status),
        .push         (push),
        .push_entry   (push_entry)
    );

    rmrd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (queue_status)
    );

    rmrd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .marker_value  (marker_reg),
        .frame_size    (frame_size_reg),
        .queue_status  (queue_status),
        .pop_entry     (pop_entry),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .run_value     (run_value),
        .run_length    (run_length),
        .total_written (total_written),
        .frame_done    (m_tlast)
    );

    // Pack the result fields, lowest first
    assign m_tdata = OUT_W'({total_written, run_length, run_value});

endmodule

[verif/rle_marker_run_decoder_core_test.sv]
`timescale 1ns / 1ps

module rle_marker_run_decoder_core_test;

    localparam int unsigned SIZE_BITS = 24;
    localparam int unsigned TDATA_W   = ((17 + SIZE_BITS + 7) / 8) * 8;

    // One decoded run as the block reports it
    typedef struct {
        logic [7:0]           value;
        logic [8:0]           length;
        logic [SIZE_BITS-1:0] total;
        logic                 done;
    } decoded_run_t;

    // Tracks the decoder state and the runs still owed by the block
    class run_scoreboard;
        logic [7:0]           marker;
        logic [SIZE_BITS-1:0] frame_size;
        logic [SIZE_BITS-1:0] written;
        bit                   count_pending;
        decoded_run_t         runs_due[$];
        int                   errors;
        int                   runs_checked;

        function new();
            marker        = '0;
            frame_size    = '0;
            written       = '0;
            count_pending = 1'b0;
            errors        = 0;
            runs_checked  = 0;
        endfunction

        function void write_reg(rmrd_pkg::cfg_index_t idx, logic [SIZE_BITS-1:0] data);
            case (idx)
                rmrd_pkg::CFG_MARKER_VALUE: marker = data[7:0];
                rmrd_pkg::CFG_FRAME_SIZE:   frame_size = data;
                default: ;
            endcase
        endfunction

        function bit frame_full();
            return written >= frame_size;
        endfunction

        function int pending();
            return runs_due.size();
        endfunction

        // Clamp a run to the room left in the frame and queue it
        function void push_run(logic [7:0] value, int unsigned len);
            decoded_run_t r;
            int unsigned  room;
            room = 32'(frame_size - written);
            if (len > room)
                len = room;
            written  = written + SIZE_BITS'(len);
            r.value  = value;
            r.length = len[8:0];
            r.total  = written;
            r.done   = (written == frame_size);
            runs_due.push_back(r);
        endfunction

        // Advance the decoder by one accepted byte; report whether it was used
        function bit note_byte(logic [7:0] code, bit start);
            if (start)
            begin
                written       = '0;
                count_pending = 1'b0;
            end
            if (frame_full())
                return 1'b0;
            if (count_pending)
            begin
                count_pending = 1'b0;
                push_run(marker, 32'(code) + 1);
            end
            else if (code == marker)
                count_pending = 1'b1;
            else
                push_run(code, 1);
            return 1'b1;
        endfunction

        // Compare one result with the oldest run owed
        function void check_run(logic [TDATA_W-1:0] data, logic last);
            decoded_run_t r;
            if (runs_due.size() == 0)
            begin
                $error("run with none expected: tdata %0h tlast %0b", data, last);
                errors++;
                return;
            end
            r = runs_due.pop_front();
            runs_checked++;
            if (data[7:0] !== r.value)
            begin
                $error("run_value: expected %0h, actual %0h", r.value, data[7:0]);
                errors++;
            end
            if (data[16:8] !== r.length)
            begin
                $error("run_length: expected %0d, actual %0d", r.length, data[16:8]);
                errors++;
            end
            if (data[17 +: SIZE_BITS] !== r.total)
            begin
                $error("total_written: expected %0d, actual %0d", r.total,
                       data[17 +: SIZE_BITS]);
                errors++;
            end
            if (last !== r.done)
            begin
                $error("frame_done: expected %0b, actual %0b", r.done, last);
                errors++;
            end
            if ((data >> (17 + SIZE_BITS)) !== '0)
            begin
                $error("tdata fill: expected 0, actual %0h", data >> (17 + SIZE_BITS));
                errors++;
            end
        endfunction
    endclass

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tlast;
    logic                 cfg_wr_en = 1'b0;
    rmrd_pkg::cfg_index_t cfg_index = rmrd_pkg::CFG_MARKER_VALUE;
    logic [SIZE_BITS-1:0] cfg_data  = '0;

    run_scoreboard runs = new();

    int send_idle_pct = 20;
    int recv_idle_pct = 84;
    int hold_request  = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int decoded_items = 0;
    int reg_writes    = 0;

    rle_marker_run_decoder_core #(.SIZE_BITS(SIZE_BITS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Receiver: hold off for a requested stretch, else stall at random
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every result taken by the receiver
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            runs.check_run(m_tdata, m_tlast);
    end

    // Offer one item after a random gap and hold it until taken
    task automatic send_item(input logic [7:0] code, input bit start);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (runs.note_byte(code, start))
            decoded_items++;
    endtask

    // Stop sending and wait until every owed run has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        while (runs.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input rmrd_pkg::cfg_index_t idx,
                             input logic [SIZE_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        runs.write_reg(idx, data);
        reg_writes++;
        @(posedge clk);
    endtask

    // Count byte after a marker: mostly short, sometimes the extremes
    function automatic logic [7:0] run_count();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return runs.marker;
            3, 4:    return 8'($urandom);
            default: return 8'($urandom_range(7));
        endcase
    endfunction

    // Frames of literals and marker pairs, with cut frames and stray bytes
    task automatic random_segment(input int n_items);
        int         goal;
        int         pick;
        bit         fresh;
        logic [7:0] code;
        goal  = items_sent + n_items;
        fresh = 1'b1;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            if (runs.frame_full() || pick < 3)
            begin
                if (runs.frame_full())
                    repeat ($urandom_range(2)) send_item(8'($urandom), 1'b0);
                fresh = 1'b1;
            end
            if (pick < 62)
            begin
                code = 8'($urandom);
                if (code == runs.marker)
                    code = code ^ 8'h01;
                send_item(code, fresh);
            end
            else if (pick < 92)
            begin
                send_item(runs.marker, fresh);
                send_item(run_count(), $urandom_range(19) == 0);
            end
            else
                send_item(8'($urandom), fresh | ($urandom_range(3) == 0));
            fresh = 1'b0;
        end
    endtask

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int                   seg;
        logic [7:0]           mark;
        logic [SIZE_BITS-1:0] fsize;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Frame size is zero after reset: drop everything
        send_item(8'h00, 1'b1);
        send_item(8'h5A, 1'b0);
        drain();

        // Marker write with junk in the upper data bits
        write_reg(rmrd_pkg::CFG_MARKER_VALUE, 24'hFFFFA5);
        write_reg(rmrd_pkg::CFG_FRAME_SIZE, 24'd10);
        send_item(8'h00, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'hA5, 1'b0);
        // count equal to the marker, clamped to fill the frame
        send_item(8'hA5, 1'b0);
        send_item(8'h12, 1'b0);
        send_item(8'hA5, 1'b1);
        send_item(8'h00, 1'b0);
        // pending marker dropped by a new frame
        send_item(8'hA5, 1'b0);
        send_item(8'h33, 1'b1);
        drain();

        // Longest run
        write_reg(rmrd_pkg::CFG_FRAME_SIZE, 24'd300);
        send_item(8'hA5, 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h01, 1'b0);
        drain();

        // Frame size cut below the count already written
        write_reg(rmrd_pkg::CFG_FRAME_SIZE, 24'd100);
        send_item(8'h44, 1'b0);
        send_item(8'hA5, 1'b0);
        send_item(8'h44, 1'b1);
        drain();

        write_reg(rmrd_pkg::CFG_MARKER_VALUE, 24'h000000);
        write_reg(rmrd_pkg::CFG_FRAME_SIZE, 24'hFFFFFF);
        send_item(8'h00, 1'b1);
        send_item(8'h05, 1'b0);
        send_item(8'hFF, 1'b0);
        drain();
        write_reg(rmrd_pkg::CFG_MARKER_VALUE, 24'h0000FF);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b0);

        // Random frames under three idling patterns
        for (seg = 0; seg < 6; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 20;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            case (seg % 3)
                0:       mark = 8'h00;
                1:       mark = 8'hFF;
                default: mark = 8'($urandom);
            endcase
            write_reg(rmrd_pkg::CFG_MARKER_VALUE, {16'($urandom), mark});
            if (seg == 3)
                fsize = 24'hFFFFFF;
            else if (seg == 5)
                fsize = 24'd1;
            else
                fsize = SIZE_BITS'($urandom_range(60, 2));
            write_reg(rmrd_pkg::CFG_FRAME_SIZE, fsize);
            random_segment(250);
        end

        // Long receiver hold-off while literals keep coming
        drain();
        write_reg(rmrd_pkg::CFG_FRAME_SIZE, 24'd1000);
        fork
            begin
                @(negedge clk);
                hold_request = 300;
            end
        join_none
        send_item(8'($urandom), 1'b1);
        repeat (39)
        begin
            mark = 8'($urandom);
            if (mark == runs.marker)
                mark = mark ^ 8'h80;
            send_item(mark, 1'b0);
        end
        drain();

        $display("Sent %0d items (%0d decoded), checked %0d runs, %0d register writes,",
                 items_sent, decoded_items, runs.runs_checked, reg_writes);
        $display("over marker and frame size extremes and three idling patterns");
        if (runs.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[rle_marker_run_decoder_core.f]
rtl/rmrd_pkg.sv
rtl/rmrd_front.sv
rtl/rmrd_queue.sv
rtl/rmrd_back.sv
rtl/rle_marker_run_decoder_core.sv
verif/rle_marker_run_decoder_core_test.sv
